// File: rtl/tss_pkg.sv
// Shared types and codes for the thread slice scheduler.
// No dependencies.
package tss_pkg;

  localparam int ID_W = 10;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_SLICE = 2'd2;
  localparam logic [1:0] KIND_YIELD = 2'd3;

  localparam logic [1:0] EV_DISPATCH = 2'd0;
  localparam logic [1:0] EV_FINISH   = 2'd1;
  localparam logic [1:0] EV_NONE     = 2'd2;

  localparam logic [2:0] POL_RING = 3'd0;
  localparam logic [2:0] POL_RR   = 3'd1;
  localparam logic [2:0] POL_SJF  = 3'd3;
  localparam logic [2:0] POL_PSJF = 3'd4;

  localparam logic [1:0] REG_POLICY   = 2'd0;
  localparam logic [1:0] REG_RR_LIMIT = 2'd1;
  localparam logic [1:0] REG_SLICE    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  budget_quanta;
    logic [15:0] release_time;
    logic [7:0]  ticks_used;
  } item_t;

endpackage

// File: rtl/tss_front.sv
// Input side: accepts words and holds them in a two-entry queue.
// Depends on tss_pkg.
module tss_front import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       buf_q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = buf_q[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (fill == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 2'd1))
    else $error("fill count lost a push");

endmodule

// File: rtl/tss_core.sv
// Back side: task slots, ring, parked store, policy sequencer, result register.
// Depends on tss_pkg.
module tss_core import tss_pkg::*; #(
  parameter int MAX_TASKS  = 16,
  parameter int MAX_PARKED = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       event_res,
  output logic [ID_W-1:0]  task_id,
  output logic [7:0]       slice,
  output logic [15:0]      elapsed,
  output logic             last
);

  localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int PW  = (MAX_PARKED > 1) ? $clog2(MAX_PARKED) : 1;
  localparam int PCW = $clog2(MAX_PARKED + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REL    = 4'd1;
  localparam logic [3:0] S_POST   = 4'd2;
  localparam logic [3:0] S_FIN    = 4'd3;
  localparam logic [3:0] S_SCHED  = 4'd4;
  localparam logic [3:0] S_PINIT  = 4'd5;
  localparam logic [3:0] S_PSTEP  = 4'd6;
  localparam logic [3:0] S_UNLINK = 4'd7;
  localparam logic [3:0] S_DISP   = 4'd8;
  localparam logic [3:0] S_NONE   = 4'd9;

  logic [MAX_TASKS-1:0] slot_valid;
  logic [ID_W-1:0]      slot_id    [MAX_TASKS];
  logic [16:0]          slot_rem   [MAX_TASKS];
  logic [15:0]          slot_start [MAX_TASKS];
  logic [3:0]           slot_pass  [MAX_TASKS];
  logic [TW-1:0]        ring_next  [MAX_TASKS];
  logic [TW-1:0]        ring_prev  [MAX_TASKS];
  logic [15:0]          park_budget  [MAX_PARKED];
  logic [15:0]          park_release [MAX_PARKED];

  logic [3:0]      state;
  logic [CW-1:0]   task_count;
  logic [PCW-1:0]  park_count;
  logic [TW-1:0]   current_slot;
  logic [15:0]     system_time;
  logic [ID_W-1:0] next_task_id;
  logic            running_flag;
  logic [2:0]      policy;
  logic [3:0]      rr_limit;
  logic [7:0]      slice_ticks;

  logic            ret_start;
  logic            exited;
  logic            yielded;
  logic [TW-1:0]   cslot;
  logic [PCW-1:0]  rel_i;
  logic [PCW-1:0]  rel_kept;
  logic [TW-1:0]   pick_start;
  logic [TW-1:0]   pick_t;
  logic [TW-1:0]   pick_best;
  logic [16:0]     best_rem;
  logic [ID_W-1:0] best_id;
  logic [CW-1:0]   pick_k;
  logic [CW-1:0]   pick_steps;

  logic [TW-1:0]   free_slot;
  logic            out_free;
  logic            res_load;
  logic [TW-1:0]   step_t;
  logic            is_sjf;
  logic [PW-1:0]   ri;
  logic [PW-1:0]   rk;
  logic [3:0]      pass_inc;
  logic [16:0]     disp_rem;

  always_comb begin
    free_slot = '0;
    for (int j = MAX_TASKS - 1; j >= 0; j--) begin
      if (!slot_valid[j]) free_slot = TW'(j);
    end
  end

  assign out_free = !out_valid || out_ready;
  assign res_load = out_free && (state == S_FIN || state == S_DISP || state == S_NONE);
  assign step_t   = ring_next[pick_t];
  assign is_sjf   = (policy == POL_SJF) || (policy == POL_PSJF);
  assign ri       = rel_i[PW-1:0];
  assign rk       = rel_kept[PW-1:0];
  assign pass_inc = slot_pass[cslot] + 4'd1;
  assign disp_rem = slot_rem[current_slot];
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_valid   <= '0;
      task_count   <= '0;
      park_count   <= '0;
      current_slot <= '0;
      system_time  <= '0;
      next_task_id <= ID_W'(1);
      running_flag <= 1'b0;
      policy       <= POL_RING;
      rr_limit     <= 4'd3;
      slice_ticks  <= 8'd5;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_POLICY:   policy      <= cfg_data[2:0];
          REG_RR_LIMIT: rr_limit    <= cfg_data[3:0];
          REG_SLICE:    slice_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            yielded   <= (q_item.kind == KIND_YIELD);
            cslot     <= current_slot;
            rel_i     <= '0;
            rel_kept  <= '0;
            case (q_item.kind)
              KIND_ADD: begin
                if (park_count < PCW'(MAX_PARKED)) begin
                  park_budget[park_count[PW-1:0]]  <= q_item.budget_quanta * slice_ticks;
                  park_release[park_count[PW-1:0]] <= q_item.release_time;
                  park_count <= park_count + PCW'(1);
                end
              end
              KIND_START: begin
                ret_start <= 1'b1;
                exited    <= 1'b0;
                if (!running_flag) state <= S_REL;
              end
              default: begin
                ret_start <= 1'b0;
                if (running_flag && task_count != '0) begin
                  system_time <= system_time + {8'd0, q_item.ticks_used};
                  if ({9'd0, q_item.ticks_used} >= slot_rem[current_slot]) begin
                    slot_rem[current_slot] <= '0;
                    exited <= 1'b1;
                  end else begin
                    slot_rem[current_slot] <= slot_rem[current_slot] -
                                              {9'd0, q_item.ticks_used};
                    exited <= 1'b0;
                  end
                  state <= S_REL;
                end
              end
            endcase
          end
        end

        S_REL: begin
          if (rel_i < park_count) begin
            rel_i <= rel_i + PCW'(1);
            if (system_time >= park_release[ri] && task_count < CW'(MAX_TASKS)) begin
              slot_valid[free_slot] <= 1'b1;
              slot_id[free_slot]    <= next_task_id;
              slot_rem[free_slot]   <= {1'b0, park_budget[ri]};
              slot_start[free_slot] <= system_time;
              slot_pass[free_slot]  <= '0;
              next_task_id          <= next_task_id + ID_W'(1);
              task_count            <= task_count + CW'(1);
              if (task_count == '0) begin
                current_slot          <= free_slot;
                ring_next[free_slot]  <= free_slot;
                ring_prev[free_slot]  <= free_slot;
              end else begin
                ring_next[ring_prev[current_slot]] <= free_slot;
                ring_prev[free_slot]  <= ring_prev[current_slot];
                ring_next[free_slot]  <= current_slot;
                ring_prev[current_slot] <= free_slot;
              end
            end else begin
              park_budget[rk]  <= park_budget[ri];
              park_release[rk] <= park_release[ri];
              rel_kept <= rel_kept + PCW'(1);
            end
          end else begin
            park_count <= rel_kept;
            state      <= S_POST;
          end
        end

        S_POST: begin
          if (ret_start) begin
            if (task_count == '0) begin
              state <= S_NONE;
            end else if (is_sjf) begin
              pick_start <= current_slot;
              pick_steps <= task_count;
              state      <= S_PINIT;
            end else begin
              state <= S_DISP;
            end
          end else if (exited) begin
            state <= S_FIN;
          end else begin
            state <= S_SCHED;
          end
        end

        S_FIN: begin
          if (out_free) begin
            event_res <= EV_FINISH;
            task_id   <= slot_id[cslot];
            slice     <= '0;
            elapsed   <= system_time - slot_start[cslot];
            last      <= 1'b0;
            if (task_count > CW'(1)) begin
              state <= S_SCHED;
            end else begin
              slot_valid[cslot] <= 1'b0;
              task_count   <= '0;
              running_flag <= 1'b0;
              state        <= S_NONE;
            end
          end
        end

        S_SCHED: begin
          if (exited) begin
            if (is_sjf) begin
              pick_start <= ring_next[cslot];
              pick_steps <= task_count - CW'(1);
              state      <= S_PINIT;
            end else begin
              current_slot <= ring_next[cslot];
              state        <= S_UNLINK;
            end
          end else if (is_sjf && (yielded || policy == POL_PSJF)) begin
            pick_start <= cslot;
            pick_steps <= task_count;
            state      <= S_PINIT;
          end else begin
            state <= S_DISP;
            case (policy)
              POL_RING: current_slot <= ring_next[cslot];
              POL_RR: begin
                if (yielded || pass_inc == rr_limit) begin
                  slot_pass[cslot] <= '0;
                  current_slot     <= ring_next[cslot];
                end else begin
                  slot_pass[cslot] <= pass_inc;
                end
              end
              default: ;
            endcase
          end
        end

        S_PINIT: begin
          pick_t    <= pick_start;
          pick_best <= pick_start;
          best_rem  <= slot_rem[pick_start];
          best_id   <= slot_id[pick_start];
          pick_k    <= CW'(1);
          state     <= S_PSTEP;
        end

        S_PSTEP: begin
          if (pick_k >= pick_steps) begin
            current_slot <= pick_best;
            state        <= exited ? S_UNLINK : S_DISP;
          end else begin
            pick_t <= step_t;
            pick_k <= pick_k + CW'(1);
            if (slot_rem[step_t] < best_rem ||
                (slot_rem[step_t] == best_rem && slot_id[step_t] < best_id)) begin
              pick_best <= step_t;
              best_rem  <= slot_rem[step_t];
              best_id   <= slot_id[step_t];
            end
          end
        end

        S_UNLINK: begin
          ring_next[ring_prev[cslot]] <= ring_next[cslot];
          ring_prev[ring_next[cslot]] <= ring_prev[cslot];
          slot_valid[cslot] <= 1'b0;
          task_count <= task_count - CW'(1);
          state      <= S_DISP;
        end

        S_DISP: begin
          if (out_free) begin
            event_res    <= EV_DISPATCH;
            task_id      <= slot_id[current_slot];
            slice        <= (disp_rem < {9'd0, slice_ticks}) ? disp_rem[7:0] : slice_ticks;
            elapsed      <= '0;
            last         <= 1'b1;
            running_flag <= 1'b1;
            state        <= S_IDLE;
          end
        end

        S_NONE: begin
          if (out_free) begin
            event_res <= EV_NONE;
            task_id   <= '0;
            slice     <= '0;
            elapsed   <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) running_flag |-> (task_count != '0))
    else $error("running with no tasks");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(slot_valid) == task_count))
    else $error("slot valid bits disagree with task count");
  assert property (@(posedge clk) disable iff (rst) park_count <= PCW'(MAX_PARKED))
    else $error("parked count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PSTEP) |-> (pick_k <= pick_steps || pick_steps == '0))
    else $error("pick walked past ring length");

endmodule

// File: rtl/thread_slice_scheduler.sv
// Top level of the thread slice scheduler: input queue plus scheduling core.
// Depends on tss_pkg, tss_front, tss_core.
//
//  channel  handshake              payload
//  in       in_valid / in_ready    kind, budget_quanta, release_time, ticks_used
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//  out      out_valid / out_ready  event_res, task_id, slice, elapsed, last
//
// An add is parked directly. Start, slice and yield first walk the parked entries, then
// post a result; a finish is followed by the next dispatch, or by a none result if no task is left.
// SJF and preemptive SJF add a ring walk over the tasks to pick the shortest.
// Two-entry input queue keeps accepting while the core works; one result register
// holds the core in its result state while out_ready is low. cfg_ready is always high.
// Synchronous reset clears all slots and parked entries at once; no clearing pass.
module thread_slice_scheduler import tss_pkg::*; #(
  parameter int MAX_TASKS  = 16,
  parameter int MAX_PARKED = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [7:0]       budget_quanta,
  input  logic [15:0]      release_time,
  input  logic [7:0]       ticks_used,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       event_res,
  output logic [ID_W-1:0]  task_id,
  output logic [7:0]       slice,
  output logic [15:0]      elapsed,
  output logic             last
);

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  assign cfg_ready = 1'b1;
  assign in_item   = '{kind: kind, budget_quanta: budget_quanta,
                       release_time: release_time, ticks_used: ticks_used};

  tss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tss_core #(
    .MAX_TASKS  (MAX_TASKS),
    .MAX_PARKED (MAX_PARKED)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .event_res (event_res),
    .task_id   (task_id),
    .slice     (slice),
    .elapsed   (elapsed),
    .last      (last)
  );

endmodule

// File: sim/thread_slice_scheduler_chk.sv
// Checker for the thread slice scheduler: watches the input, config and result channels,
// models the scheduler state and compares every result word. Depends on tss_pkg.
module thread_slice_scheduler_chk import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  budget_quanta,
  input  logic [15:0] release_time,
  input  logic [7:0]  ticks_used,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  event_res,
  input  logic [9:0]  task_id,
  input  logic [7:0]  slice,
  input  logic [15:0] elapsed,
  input  logic        last,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = 16;
  localparam int NP = 16;

  typedef struct packed {
    logic [1:0]  ev;
    logic [9:0]  id;
    logic [7:0]  sl;
    logic [15:0] el;
    logic        lst;
  } word_t;

  word_t sched_q[$];

  logic [2:0]  pol;
  logic [3:0]  rr_lim;
  logic [7:0]  qticks;
  bit          t_valid[NT];
  logic [9:0]  t_id[NT];
  logic [16:0] t_rem[NT];
  logic [15:0] t_start[NT];
  logic [3:0]  t_pass[NT];
  int          nxt[NT];
  int          prv[NT];
  int          n_tasks;
  logic [16:0] pk_budget[NP];
  logic [15:0] pk_rel[NP];
  int          n_parked;
  int          cur;
  logic [15:0] now;
  logic [9:0]  next_id;
  bit          running;

  assign pending = sched_q.size();

  function automatic void clear_state();
    pol = POL_RING; rr_lim = 4'd3; qticks = 8'd5;
    for (int i = 0; i < NT; i++) begin
      t_valid[i] = 0; nxt[i] = 0; prv[i] = 0;
    end
    n_tasks = 0; n_parked = 0; cur = 0; now = '0; next_id = 10'd1; running = 0;
  endfunction

  function automatic void push(logic [1:0] ev, logic [9:0] id, logic [7:0] sl,
                               logic [15:0] el, logic lst);
    word_t w;
    w.ev = ev; w.id = id; w.sl = sl; w.el = el; w.lst = lst;
    sched_q.push_back(w);
  endfunction

  function automatic void admit_task(logic [16:0] b);
    int s;
    int p;
    s = 0;
    while (s < NT && t_valid[s]) s++;
    if (s >= NT) return;
    t_valid[s] = 1; t_id[s] = next_id; next_id = next_id + 10'd1;
    t_rem[s] = b; t_start[s] = now; t_pass[s] = '0;
    if (n_tasks == 0) begin
      cur = s; nxt[s] = s; prv[s] = s;
    end else begin
      p = prv[cur];
      nxt[p] = s; prv[s] = p; nxt[s] = cur; prv[cur] = s;
    end
    n_tasks++;
  endfunction

  function automatic void release_parked();
    int kept;
    kept = 0;
    for (int i = 0; i < n_parked; i++) begin
      if (now >= pk_rel[i] && n_tasks < NT) admit_task(pk_budget[i]);
      else begin
        pk_budget[kept] = pk_budget[i]; pk_rel[kept] = pk_rel[i]; kept++;
      end
    end
    n_parked = kept;
  endfunction

  function automatic int shortest_in_ring(int first, int steps);
    int best;
    int t;
    best = first; t = first;
    for (int k = 1; k < steps; k++) begin
      t = nxt[t];
      if (t_rem[t] < t_rem[best] || (t_rem[t] == t_rem[best] && t_id[t] < t_id[best]))
        best = t;
    end
    return best;
  endfunction

  function automatic void pick_next(bit exited, bit yielded);
    int c;
    c = cur;
    case (pol)
      POL_RING: cur = nxt[c];
      POL_RR: begin
        if (exited) cur = nxt[c];
        else if (yielded || (t_pass[c] + 4'd1) == rr_lim) begin
          t_pass[c] = '0; cur = nxt[c];
        end else t_pass[c] = t_pass[c] + 4'd1;
      end
      POL_SJF: begin
        if (exited) cur = shortest_in_ring(nxt[c], n_tasks - 1);
        else if (yielded) cur = shortest_in_ring(c, n_tasks);
      end
      POL_PSJF: begin
        if (exited) cur = shortest_in_ring(nxt[c], n_tasks - 1);
        else cur = shortest_in_ring(c, n_tasks);
      end
      default: if (exited) cur = nxt[c];
    endcase
  endfunction

  function automatic void push_dispatch();
    logic [16:0] sl;
    sl = (t_rem[cur] < {9'd0, qticks}) ? t_rem[cur] : {9'd0, qticks};
    push(EV_DISPATCH, t_id[cur], sl[7:0], '0, 1'b1);
  endfunction

  function automatic void run_report(logic [7:0] tk, bit yielded);
    int c;
    int n;
    int p;
    if (!running || n_tasks == 0) return;
    c = cur;
    now = now + {8'd0, tk};
    if ({9'd0, tk} >= t_rem[c]) begin
      t_rem[c] = '0;
      release_parked();
      push(EV_FINISH, t_id[c], '0, now - t_start[c], 1'b0);
      if (n_tasks > 1) begin
        pick_next(1, yielded);
        n = nxt[c]; p = prv[c];
        nxt[p] = n; prv[n] = p;
        t_valid[c] = 0; n_tasks--;
        push_dispatch();
      end else begin
        t_valid[c] = 0; n_tasks = 0; running = 0;
        push(EV_NONE, '0, '0, '0, 1'b1);
      end
      return;
    end
    t_rem[c] = t_rem[c] - {9'd0, tk};
    release_parked();
    pick_next(0, yielded);
    push_dispatch();
  endfunction

  function automatic void accept_word(logic [1:0] k, logic [7:0] q, logic [15:0] rel,
                                      logic [7:0] tk);
    case (k)
      KIND_ADD: if (n_parked < NP) begin
        pk_budget[n_parked] = q * qticks; pk_rel[n_parked] = rel; n_parked++;
      end
      KIND_START: if (!running) begin
        release_parked();
        if (n_tasks == 0) push(EV_NONE, '0, '0, '0, 1'b1);
        else begin
          if (pol == POL_SJF || pol == POL_PSJF) cur = shortest_in_ring(cur, n_tasks);
          running = 1;
          push_dispatch();
        end
      end
      default: run_report(tk, k == KIND_YIELD);
    endcase
  endfunction

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      clear_state();
      sched_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POLICY:   pol = cfg_data[2:0];
          REG_RR_LIMIT: rr_lim = cfg_data[3:0];
          REG_SLICE:    qticks = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (sched_q.size() == 0) begin
          if (errors < 10) $display("unexpected result word ev=%0d id=%0d", event_res, task_id);
          errors <= errors + 1;
        end else begin
          w = sched_q.pop_front();
          if (w.ev !== event_res || w.id !== task_id || w.sl !== slice ||
              w.el !== elapsed || w.lst !== last) begin
            if (errors < 10)
              $display("mismatch exp ev=%0d id=%0d sl=%0d el=%0d last=%0d got %0d %0d %0d %0d %0d",
                       w.ev, w.id, w.sl, w.el, w.lst, event_res, task_id, slice, elapsed, last);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) accept_word(kind, budget_quanta, release_time, ticks_used);
    end
  end
endmodule

// File: sim/thread_slice_scheduler_tb.sv
// Testbench top for the thread slice scheduler: clock, reset, stimulus and verdict.
// Depends on tss_pkg, thread_slice_scheduler and thread_slice_scheduler_chk.
module thread_slice_scheduler_tb import tss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  kind = KIND_ADD;
  logic [7:0]  budget_quanta = '0;
  logic [15:0] release_time = '0;
  logic [7:0]  ticks_used = '0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_POLICY;
  logic [7:0]  cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  event_res;
  logic [9:0]  task_id;
  logic [7:0]  slice;
  logic [15:0] elapsed;
  logic        last;
  int          errors;
  int          pending;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          quiet = 0;
  logic [15:0] sim_now = '0;

  always #2 clk = ~clk;

  thread_slice_scheduler i_dut (.*);

  thread_slice_scheduler_chk i_chk (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // called at a falling edge; in_ready only moves at rising edges
  task automatic send(logic [1:0] k, logic [7:0] q, logic [15:0] rel, logic [7:0] tk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_valid <= 1; kind <= k; budget_quanta <= q; release_time <= rel; ticks_used <= tk;
    if (k == KIND_SLICE || k == KIND_YIELD) sim_now = sim_now + {8'd0, tk};
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // random mix of adds, starts and scheduling reports, mostly reports, with some noise
  task automatic random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25)
        send(KIND_ADD,
             $urandom_range(99) < 90 ? 8'($urandom_range(6)) : 8'($urandom_range(255)),
             $urandom_range(99) < 85 ? sim_now + 16'($urandom_range(40))
                                     : 16'($urandom_range(65535)),
             8'($urandom_range(255)));
      else if (r < 33) send(KIND_START, 8'($urandom), 16'($urandom), 8'($urandom));
      else begin
        send(r < 80 ? KIND_SLICE : KIND_YIELD, 8'($urandom), 16'($urandom),
             $urandom_range(99) < 80 ? 8'($urandom_range(12)) : 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_idle = 15; recv_idle = 82;
    // directed: empty start, stray reports, extremes, ID order, yield
    send(KIND_START, 8'hff, 16'hffff, 8'hff);
    send(KIND_SLICE, 8'h00, 16'h0000, 8'h05);
    send(KIND_YIELD, 8'hff, 16'hffff, 8'hff);
    send(KIND_ADD, 8'd2, 16'd0, 8'd0);
    send(KIND_ADD, 8'd255, 16'd0, 8'hff);
    send(KIND_ADD, 8'd1, 16'd3, 8'd0);
    send(KIND_ADD, 8'd0, 16'hffff, 8'd0);
    send(KIND_START, 8'd0, 16'd0, 8'd0);
    send(KIND_START, 8'd0, 16'd0, 8'd0);
    send(KIND_SLICE, 8'd0, 16'd0, 8'd3);
    send(KIND_YIELD, 8'd0, 16'd0, 8'd0);
    send(KIND_SLICE, 8'd0, 16'd0, 8'd255);
    send(KIND_SLICE, 8'd0, 16'd0, 8'd255);
    send(KIND_YIELD, 8'd0, 16'd0, 8'd255);
    send(KIND_SLICE, 8'd0, 16'd0, 8'd255);
    for (int i = 0; i < 18; i++) send(KIND_ADD, 8'(i), 16'd0, 8'd0);
    send(KIND_START, 8'd0, 16'd0, 8'd0);
    random_burst(40);
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle = 82; recv_idle = 15;
      end
      if (ph == 6) begin
        send_idle = 0; recv_idle = 0;
      end
      write_reg(REG_POLICY, 8'(ph < 5 ? ph : $urandom_range(7)));
      write_reg(REG_RR_LIMIT, ph == 0 ? 8'd1 : ph == 1 ? 8'd15 : 8'($urandom_range(15)));
      write_reg(REG_SLICE, ph == 0 ? 8'd1 : ph == 1 ? 8'd255 : 8'($urandom_range(1, 20)));
      random_burst(50);
    end
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: sim.f
rtl/tss_pkg.sv
rtl/tss_front.sv
rtl/tss_core.sv
rtl/thread_slice_scheduler.sv
sim/thread_slice_scheduler_chk.sv
sim/thread_slice_scheduler_tb.sv
